// ===== hw/rtl/xtea_block_cipher_macros.svh =====
// Assertion macros shared by the XTEA cipher RTL.
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XTEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XTEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold after the delay given by dly, counted from the antecedent.
`define XTEA_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/xtea_pkg.sv =====
// Constants, codes and the round mixing function of the XTEA cipher.
package xtea_pkg;

    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 8;

    localparam logic [WORD_W-1:0] DELTA     = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] NEG_DELTA = 32'h61C8_8647;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] KEY_WORD0_IDX = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD1_IDX = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD2_IDX = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD3_IDX = 8'd3;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t mix(input word_t v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

// ===== hw/rtl/xtea_block_cipher.sv =====
// XTEA block cipher: fully unrolled pipeline of Feistel half-rounds.
//
// One 64-bit block is accepted on every cycle that start is high (busy is
// always low), and its result appears on out_left/out_right with done high
// for exactly one cycle once the block has passed through every pipeline
// stage in turn. The receiver cannot hold a result off, so it must take
// each one in the cycle that done is high. Each pipeline stage performs one
// Feistel half-round, so the latency is set by the number of stages and the
// throughput is one block per clock regardless of the mix of encrypt and
// decrypt requests. The four key words are written through the configuration
// channel, which is always ready; a key change takes effect on blocks in
// flight, so write the key only while no request is in the pipeline.
`include "xtea_block_cipher_macros.svh"

module xtea_block_cipher #(
    parameter int CYCLES = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Block request channel.
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [31:0]                        in_left,
    input  logic [31:0]                        in_right,
    // Result channel.
    output logic                               done,
    output logic [31:0]                        out_left,
    output logic [31:0]                        out_right,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    localparam int STAGES = 2 * CYCLES;

    xtea_pkg::word_t key_reg [0:3];

    logic [STAGES-1:0] valid_reg;
    logic              kind_reg [0:STAGES-1];
    xtea_pkg::word_t   v0_reg   [0:STAGES-1];
    xtea_pkg::word_t   v1_reg   [0:STAGES-1];

    // Stage inputs: entry 0 comes from the ports, entry s+1 from stage s.
    logic              lane_valid [0:STAGES];
    logic              lane_kind  [0:STAGES];
    xtea_pkg::word_t   lane_v0    [0:STAGES];
    xtea_pkg::word_t   lane_v1    [0:STAGES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                xtea_pkg::KEY_WORD0_IDX: key_reg[0] <= cfg_data;
                xtea_pkg::KEY_WORD1_IDX: key_reg[1] <= cfg_data;
                xtea_pkg::KEY_WORD2_IDX: key_reg[2] <= cfg_data;
                xtea_pkg::KEY_WORD3_IDX: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lane_valid[0] = start && !busy;
    assign lane_kind[0]  = kind;
    assign lane_v0[0]    = in_left;
    assign lane_v1[0]    = in_right;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        // Round sums are fixed per stage for each direction.
        localparam int N   = s / 2;
        localparam int ODD = s % 2;
        localparam logic [63:0] ENC_PROD = 64'(N + ODD) * 64'(xtea_pkg::DELTA);
        localparam logic [63:0] DEC_PROD = 64'(CYCLES - N - ODD) * 64'(xtea_pkg::DELTA);
        localparam logic [31:0] SUM_E = ENC_PROD[31:0];
        localparam logic [31:0] SUM_D = DEC_PROD[31:0];
        localparam logic [1:0]  IDX_E = (ODD != 0) ? SUM_E[12:11] : SUM_E[1:0];
        localparam logic [1:0]  IDX_D = (ODD != 0) ? SUM_D[1:0] : SUM_D[12:11];
        localparam logic        STAGE_ODD = (ODD != 0);

        logic            tgt_is_v0;
        xtea_pkg::word_t src;
        xtea_pkg::word_t tgt;
        xtea_pkg::word_t round_key;
        xtea_pkg::word_t f_val;
        xtea_pkg::word_t new_val;
        logic            v0_sel;

        // Encryption updates the left word on even stages, decryption on odd.
        assign tgt_is_v0 = (lane_kind[s] == STAGE_ODD);
        assign src       = tgt_is_v0 ? lane_v1[s] : lane_v0[s];
        assign tgt       = tgt_is_v0 ? lane_v0[s] : lane_v1[s];
        assign round_key = (lane_kind[s] == xtea_pkg::KIND_DECRYPT)
                           ? SUM_D + key_reg[IDX_D]
                           : SUM_E + key_reg[IDX_E];
        assign f_val     = xtea_pkg::mix(src) ^ round_key;
        assign new_val   = (lane_kind[s] == xtea_pkg::KIND_DECRYPT)
                           ? tgt - f_val : tgt + f_val;
        assign v0_sel    = tgt_is_v0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= lane_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            kind_reg[s] <= lane_kind[s];
            v0_reg[s]   <= v0_sel ? new_val : lane_v0[s];
            v1_reg[s]   <= v0_sel ? lane_v1[s] : new_val;
        end

        assign lane_valid[s+1] = valid_reg[s];
        assign lane_kind[s+1]  = kind_reg[s];
        assign lane_v0[s+1]    = v0_reg[s];
        assign lane_v1[s+1]    = v1_reg[s];
    end

    assign done      = lane_valid[STAGES];
    assign out_left  = lane_v0[STAGES];
    assign out_right = lane_v1[STAGES];

    // Every accepted block leaves with done once it is through the whole pipeline.
    `XTEA_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, STAGES, done,
        "accepted block did not complete after the pipeline depth")
    // No result without a matching earlier request.
    `XTEA_ASSERT_NOW(a_no_spurious, clk, rst_n, done, $past(start && !busy, STAGES),
        "result strobe without a matching request")
    // A write to the first key word lands in the key register.
    `XTEA_ASSERT_NEXT(a_key0_write, clk, rst_n,
        cfg_valid && cfg_ready && (cfg_index == xtea_pkg::KEY_WORD0_IDX),
        key_reg[0] == $past(cfg_data), "key word 0 write lost")

endmodule

// ===== tb/sv/tb_xtea_block_cipher.sv =====
// Self-checking testbench for the XTEA block cipher pipeline, with its own cipher predictor.
module tb_xtea_block_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLES      = 32;
    localparam int LATENCY     = 2 * CYCLES;
    localparam int STALL_LIMIT = 8 * (LATENCY + 16);
    localparam int PHASE_ITEMS = 390;
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST  = 1000;
    localparam int MAX_GAP     = 6;

    typedef logic [xtea_pkg::CFG_INDEX_W-1:0] cfg_index_t;

    typedef struct {
        logic            kind;
        xtea_pkg::word_t in_left;
        xtea_pkg::word_t in_right;
        xtea_pkg::word_t out_left;
        xtea_pkg::word_t out_right;
    } block_rec_t;

    class block_tracker;
        xtea_pkg::word_t key_word [4];
        block_rec_t      pending_blocks [$];
        int              mismatches;
        xtea_pkg::word_t last_left;
        xtea_pkg::word_t last_right;

        function new();
            foreach (key_word[i])
            begin
                key_word[i] = '0;
            end
            mismatches = 0;
            last_left  = '0;
            last_right = '0;
        endfunction

        function void load_key_word(cfg_index_t idx, xtea_pkg::word_t data);
            unique case (idx)
                xtea_pkg::KEY_WORD0_IDX: key_word[0] = data;
                xtea_pkg::KEY_WORD1_IDX: key_word[1] = data;
                xtea_pkg::KEY_WORD2_IDX: key_word[2] = data;
                xtea_pkg::KEY_WORD3_IDX: key_word[3] = data;
                default: ;
            endcase
        endfunction

        function xtea_pkg::word_t scramble(xtea_pkg::word_t v);
            return ((v << 4) ^ (v >> 5)) + v;
        endfunction

        function void run_cipher(logic k, xtea_pkg::word_t l, xtea_pkg::word_t r,
                                 output xtea_pkg::word_t res_left,
                                 output xtea_pkg::word_t res_right);
            xtea_pkg::word_t v0;
            xtea_pkg::word_t v1;
            xtea_pkg::word_t sum;
            v0 = l;
            v1 = r;
            if (k == xtea_pkg::KIND_ENCRYPT)
            begin
                sum = '0;
                for (int n = 0; n < CYCLES; n++)
                begin
                    v0  += scramble(v1) ^ (sum + key_word[sum[1:0]]);
                    sum += xtea_pkg::DELTA;
                    v1  += scramble(v0) ^ (sum + key_word[sum[12:11]]);
                end
            end
            else
            begin
                // The start sum follows the cycle count, so decryption always undoes encryption.
                sum = xtea_pkg::DELTA * xtea_pkg::word_t'(CYCLES);
                for (int n = 0; n < CYCLES; n++)
                begin
                    v1  -= scramble(v0) ^ (sum + key_word[sum[12:11]]);
                    sum -= xtea_pkg::DELTA;
                    v0  -= scramble(v1) ^ (sum + key_word[sum[1:0]]);
                end
            end
            res_left  = v0;
            res_right = v1;
        endfunction

        function void note_request(logic k, xtea_pkg::word_t l, xtea_pkg::word_t r);
            block_rec_t rec;
            rec.kind     = k;
            rec.in_left  = l;
            rec.in_right = r;
            run_cipher(k, l, r, rec.out_left, rec.out_right);
            pending_blocks.push_back(rec);
            last_left  = rec.out_left;
            last_right = rec.out_right;
        endfunction

        function void compare_word(string field, block_rec_t rec, xtea_pkg::word_t exp,
                                   xtea_pkg::word_t act);
            if (act !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: kind %0b block %08h %08h expected %08h got %08h",
                             field, rec.kind, rec.in_left, rec.in_right, exp, act);
            end
        endfunction

        function void check_block(xtea_pkg::word_t l, xtea_pkg::word_t r);
            block_rec_t rec;
            if (pending_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %08h %08h with no request outstanding", l, r);
                return;
            end
            rec = pending_blocks.pop_front();
            compare_word("out_left", rec, rec.out_left, l);
            compare_word("out_right", rec, rec.out_right, r);
        endfunction

        function int outstanding();
            return pending_blocks.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [31:0] in_left;
    logic [31:0] in_right;
    logic        done;
    logic [31:0] out_left;
    logic [31:0] out_right;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;

    block_tracker tracker = new();
    int           stall_cycles = 0;
    int           item_no = 0;

    xtea_pkg::word_t corner_words [5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                          32'h0000_0001, 32'h7FFF_FFFF};

    xtea_block_cipher #(
        .CYCLES(CYCLES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .in_left  (in_left),
        .in_right (in_right),
        .done     (done),
        .out_left (out_left),
        .out_right(out_right),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // All handshakes are observed here on pre-edge values, so the order of processes does not matter.
    always @(posedge clk)
    begin
        logic active;
        active = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                tracker.load_key_word(cfg_index, cfg_data);
                active = 1'b1;
            end
            if (start && busy === 1'b0)
            begin
                tracker.note_request(kind, in_left, in_right);
                active = 1'b1;
            end
            if (done === 1'b1)
            begin
                tracker.check_block(out_left, out_right);
                active = 1'b1;
            end
        end
        stall_cycles <= active ? 0 : stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_block(logic k, xtea_pkg::word_t l, xtea_pkg::word_t r, int gap);
        if (gap > 0)
        begin
            start    <= 1'b0;
            kind     <= 1'($urandom);
            in_left  <= $urandom;
            in_right <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        in_left  <= l;
        in_right <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic write_reg(cfg_index_t idx, xtea_pkg::word_t data);
        int gap;
        gap = ($urandom_range(0, 99) < 54) ? 1 : 0;
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
    endtask

    // Loads the key and adds one write to an unused index, which must leave the key alone.
    task automatic program_key(xtea_pkg::word_t k0, xtea_pkg::word_t k1,
                               xtea_pkg::word_t k2, xtea_pkg::word_t k3);
        write_reg(xtea_pkg::KEY_WORD0_IDX, k0);
        write_reg(xtea_pkg::KEY_WORD1_IDX, k1);
        write_reg(cfg_index_t'($urandom_range(4, 255)), $urandom);
        write_reg(xtea_pkg::KEY_WORD2_IDX, k2);
        write_reg(xtea_pkg::KEY_WORD3_IDX, k3);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    task automatic run_corner_blocks();
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                send_block(1'(k), corner_words[i], corner_words[4-i], $urandom_range(0, 2));
            end
        end
    endtask

    task automatic run_random_blocks(int count);
        int              sel;
        int              gap;
        logic            k;
        xtea_pkg::word_t l;
        xtea_pkg::word_t r;
        for (int i = 0; i < count; i++)
        begin
            k   = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                // Feed a recent result back in, mostly to run decrypt over real ciphertext.
                l = tracker.last_left;
                r = tracker.last_right;
            end
            else if (sel < 25)
            begin
                l = corner_words[$urandom_range(0, 4)];
                r = corner_words[$urandom_range(0, 4)];
            end
            else
            begin
                l = $urandom;
                r = $urandom;
            end
            if (item_no >= QUIET_FIRST && item_no < QUIET_LAST)
                gap = 0;
            else
                gap = ($urandom_range(0, 99) < 15) ? $urandom_range(1, MAX_GAP) : 0;
            send_block(k, l, r, gap);
            item_no++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = xtea_pkg::KIND_ENCRYPT;
        in_left   = '0;
        in_right  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The key is all zeros out of reset.
        run_corner_blocks();
        wait_drained();

        program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_corner_blocks();
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            unique case (p)
                1: program_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
                3: program_key($urandom, 32'h0000_0000, 32'hFFFF_FFFF, $urandom);
                default: program_key($urandom, $urandom, $urandom, $urandom);
            endcase
            run_random_blocks(PHASE_ITEMS);
            wait_drained();
        end

        repeat (LATENCY + 16) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== xtea_block_cipher.f =====
+incdir+hw/rtl
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_block_cipher.sv
tb/sv/tb_xtea_block_cipher.sv
